@@ design/frame_diff_change_centroid_top_macros.svh @@
// Assertion macros for the change-centroid block.
// Used by the modules under design/ that carry concurrent checks.
`ifndef FRAME_DIFF_CHANGE_CENTROID_TOP_MACROS_SVH
`define FRAME_DIFF_CHANGE_CENTROID_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define FDC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define FDC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ design/fdcc_pkg.sv @@
// Shared types and constants for the change-centroid block.
// No dependencies.
package fdcc_pkg;
  localparam int MaxWidth  = 2048;
  localparam int MaxHeight = 2048;
  localparam int XW = $clog2(MaxWidth);
  localparam int YW = $clog2(MaxHeight);
  localparam int CntW = 23;
  localparam int SumW = 33;
  localparam int RatW = 24;
  localparam int TolW = 24;
  localparam int ThrW = 15;
  localparam int CenW = 15;
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 24;
  localparam int QDepth = 4;
  localparam int QAw = 2;

  localparam logic [CfgIdxW-1:0] REG_THRESH = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LUMIN  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_RED    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_GREEN  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_BLUE   = 3'd4;

  typedef struct packed {
    logic          changed;
    logic [XW-1:0] x;
    logic [YW-1:0] y;
    logic          last;
  } pix_t;

  typedef enum logic [1:0] {
    ST_ACC, ST_DIV, ST_OUT
  } bst_t;
endpackage

@@ design/fdcc_front.sv @@
// Front part: per-pixel ratio and tolerance test, two register stages.
// Depends on fdcc_pkg.
module fdcc_front (
  input  logic clk,
  input  logic rst_n,
  input  logic in_go,
  input  logic [7:0] ref_b, ref_g, ref_r, cur_b, cur_g, cur_r,
  input  logic [10:0] px, py,
  input  logic lst,
  input  logic [fdcc_pkg::TolW-1:0] lum_tol, red_tol, grn_tol, blu_tol,
  output logic o_vld,
  output fdcc_pkg::pix_t o_pix
);
  localparam int RW = fdcc_pkg::RatW;
  localparam int MW = 33;
  localparam logic [63:0] RcpNum = 64'h1_0000_0000;
  logic [MW-1:0] rcp [256];
  logic [RW-1:0] rb_r, rg_r, rr_r;
  logic [10:0] x_r, y_r;
  logic l_r, v1_r, v2_r;
  logic [fdcc_pkg::XW-1:0] cx;
  logic [fdcc_pkg::YW-1:0] cy;
  logic [RW+1:0] s, t3, tb, tg, tr;
  logic ok;
  fdcc_pkg::pix_t pix_r;

  // rounded-up 2^32/ref; cur*rcp >> 16 is exactly floor(cur*65536/ref) for 8-bit operands
  for (genvar g = 0; g < 256; g++) begin : g_rcp
    if (g == 0) begin : g_zero
      assign rcp[g] = '0;
    end else begin : g_val
      assign rcp[g] = MW'((RcpNum + 64'(g) - 64'd1) / 64'(g));
    end
  end

  function automatic logic [RW-1:0] ratio(input logic [7:0] c, input logic [7:0] r,
                                          input logic [MW-1:0] m);
    logic [MW+7:0] p;
    p = (MW+8)'(m) * (MW+8)'(c);
    if (r == 8'd0) begin
      ratio = (c != 8'd0) ? {RW{1'b1}} : '0;
    end else begin
      ratio = (p[MW+7:RW+16] != '0) ? {RW{1'b1}} : p[RW+15:16];
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= in_go;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_go) begin
      rb_r <= ratio(cur_b, ref_b, rcp[ref_b]);
      rg_r <= ratio(cur_g, ref_g, rcp[ref_g]);
      rr_r <= ratio(cur_r, ref_r, rcp[ref_r]);
      x_r <= px;
      y_r <= py;
      l_r <= lst;
    end
  end

  function automatic logic [RW+1:0] adiff(input logic [RW+1:0] a, input logic [RW+1:0] b);
    adiff = (a > b) ? a - b : b - a;
  endfunction

  always_comb begin
    cx = (x_r > 11'(fdcc_pkg::MaxWidth - 1)) ? fdcc_pkg::XW'(fdcc_pkg::MaxWidth - 1)
                                              : fdcc_pkg::XW'(x_r);
    cy = (y_r > 11'(fdcc_pkg::MaxHeight - 1)) ? fdcc_pkg::YW'(fdcc_pkg::MaxHeight - 1)
                                               : fdcc_pkg::YW'(y_r);
    s  = {2'b0, rb_r} + {2'b0, rg_r} + {2'b0, rr_r};
    t3 = 26'd196608;
    tb = {2'b0, rb_r} + {1'b0, rb_r, 1'b0};
    tg = {2'b0, rg_r} + {1'b0, rg_r, 1'b0};
    tr = {2'b0, rr_r} + {1'b0, rr_r, 1'b0};
    ok = (adiff(s, t3) <= ({2'b0, lum_tol} + {1'b0, lum_tol, 1'b0}))
      && (adiff(tb, s) <= ({2'b0, blu_tol} + {1'b0, blu_tol, 1'b0}))
      && (adiff(tg, s) <= ({2'b0, grn_tol} + {1'b0, grn_tol, 1'b0}))
      && (adiff(tr, s) <= ({2'b0, red_tol} + {1'b0, red_tol, 1'b0}));
  end

  always_ff @(posedge clk) begin
    if (v1_r) begin
      pix_r.changed <= !ok;
      pix_r.x <= cx;
      pix_r.y <= cy;
      pix_r.last <= l_r;
    end
  end

  assign o_vld = v2_r;
  assign o_pix = pix_r;
endmodule

@@ design/fdcc_queue.sv @@
// Short queue between front and back parts.
// Depends on fdcc_pkg.
module fdcc_queue (
  input  logic clk,
  input  logic rst_n,
  input  logic wr,
  input  fdcc_pkg::pix_t wdata,
  input  logic rd,
  output logic nonempty,
  output fdcc_pkg::pix_t rdata,
  output logic [fdcc_pkg::QAw:0] level
);
  fdcc_pkg::pix_t mem [fdcc_pkg::QDepth];
  logic [fdcc_pkg::QAw-1:0] wp_r, rp_r;
  logic [fdcc_pkg::QAw:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (fdcc_pkg::QAw+1)'(wr) - (fdcc_pkg::QAw+1)'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wp_r] <= wdata;
  end

  assign rdata = mem[rp_r];
  assign nonempty = cnt_r != '0;
  assign level = cnt_r;
endmodule

@@ design/fdcc_back.sv @@
// Back part: accumulators, serial centroid division, result register.
// Depends on fdcc_pkg and the assertion macros header.
`include "frame_diff_change_centroid_top_macros.svh"
module fdcc_back (
  input  logic clk,
  input  logic rst_n,
  input  logic q_ne,
  input  fdcc_pkg::pix_t q_pix,
  output logic q_rd,
  input  logic [fdcc_pkg::ThrW-1:0] thr,
  output logic o_ne,
  input  logic o_pop,
  output logic o_valid,
  output logic [fdcc_pkg::CenW-1:0] o_cx, o_cy,
  output logic [fdcc_pkg::CntW-1:0] o_tot
);
  localparam int CW = fdcc_pkg::CntW;
  localparam int SW = fdcc_pkg::SumW;
  localparam int NW = SW + 4;
  localparam logic [CW-1:0] CntMax = '1;
  localparam logic [SW-1:0] SumMax = '1;

  fdcc_pkg::bst_t st_r, st_nxt;
  logic [CW-1:0] cc_r, pt_r;
  logic [SW-1:0] sx_r, sy_r;
  logic [NW-1:0] nx_r, ny_r;
  logic [CW:0] rx_r, ry_r;
  logic [19:0] qx_r, qy_r;
  logic [5:0] step_r;
  logic val_r, ne_r;
  logic [fdcc_pkg::CenW-1:0] cx_r, cy_r;
  logic [CW-1:0] tot_r;
  logic [SW:0] ax, ay;
  logic [CW:0] tx, ty;
  logic take, fin;
  logic [CW+15:0] lhs;
  logic [CW+15:0] rhs;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      fdcc_pkg::ST_ACC: if (take && q_pix.last) st_nxt = fdcc_pkg::ST_DIV;
      fdcc_pkg::ST_DIV: if (step_r == 6'(NW)) st_nxt = fdcc_pkg::ST_OUT;
      fdcc_pkg::ST_OUT: if (!ne_r) st_nxt = fdcc_pkg::ST_ACC;
      default: st_nxt = fdcc_pkg::ST_ACC;
    endcase
  end

  always_comb begin
    take = (st_r == fdcc_pkg::ST_ACC) && q_ne;
    fin = (st_r == fdcc_pkg::ST_OUT) && !ne_r;
    q_rd = take;
    lhs = {16'd0, cc_r} * 39'd25600;
    rhs = {24'd0, thr} * {16'd0, pt_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= fdcc_pkg::ST_ACC;
    else st_r <= st_nxt;
  end

  always_comb begin
    ax = {1'b0, sx_r} + {{(SW-fdcc_pkg::XW+1){1'b0}}, q_pix.x};
    ay = {1'b0, sy_r} + {{(SW-fdcc_pkg::YW+1){1'b0}}, q_pix.y};
    tx = {rx_r[CW-1:0], nx_r[NW-1]};
    ty = {ry_r[CW-1:0], ny_r[NW-1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r <= '0;
      pt_r <= '0;
      sx_r <= '0;
      sy_r <= '0;
      step_r <= '0;
      ne_r <= 1'b0;
    end else begin
      if (take) begin
        if (pt_r != CntMax) pt_r <= pt_r + 1'b1;
        if (q_pix.changed) begin
          if (cc_r != CntMax) cc_r <= cc_r + 1'b1;
          sx_r <= ax[SW] ? SumMax : ax[SW-1:0];
          sy_r <= ay[SW] ? SumMax : ay[SW-1:0];
        end
      end
      if (st_r == fdcc_pkg::ST_ACC && take && q_pix.last) begin
        nx_r <= {(q_pix.changed ? (ax[SW] ? SumMax : ax[SW-1:0]) : sx_r), 4'd0};
        ny_r <= {(q_pix.changed ? (ay[SW] ? SumMax : ay[SW-1:0]) : sy_r), 4'd0};
        rx_r <= '0;
        ry_r <= '0;
        qx_r <= '0;
        qy_r <= '0;
        step_r <= '0;
      end
      if (st_r == fdcc_pkg::ST_DIV && step_r != 6'(NW)) begin
        step_r <= step_r + 1'b1;
        nx_r <= {nx_r[NW-2:0], 1'b0};
        ny_r <= {ny_r[NW-2:0], 1'b0};
        if (tx >= {1'b0, cc_r}) begin
          rx_r <= tx - {1'b0, cc_r};
          qx_r <= {qx_r[18:0], 1'b1} | {20{qx_r[19]}};
        end else begin
          rx_r <= tx;
          qx_r <= {qx_r[18:0], 1'b0} | {20{qx_r[19]}};
        end
        if (ty >= {1'b0, cc_r}) begin
          ry_r <= ty - {1'b0, cc_r};
          qy_r <= {qy_r[18:0], 1'b1} | {20{qy_r[19]}};
        end else begin
          ry_r <= ty;
          qy_r <= {qy_r[18:0], 1'b0} | {20{qy_r[19]}};
        end
      end
      if (st_r == fdcc_pkg::ST_DIV && step_r == 6'(NW)) begin
        ne_r <= 1'b1;
        val_r <= (cc_r != '0) && (lhs > rhs);
        cx_r <= ((cc_r == '0) || !(lhs > rhs)) ? '0 :
                (qx_r > 20'd32767) ? 15'd32767 : qx_r[14:0];
        cy_r <= ((cc_r == '0) || !(lhs > rhs)) ? '0 :
                (qy_r > 20'd32767) ? 15'd32767 : qy_r[14:0];
        tot_r <= cc_r;
      end
      if (ne_r && o_pop) ne_r <= 1'b0;
      if (fin) begin
        cc_r <= '0;
        pt_r <= '0;
        sx_r <= '0;
        sy_r <= '0;
      end
    end
  end

  assign o_ne = ne_r;
  assign o_valid = val_r;
  assign o_cx = cx_r;
  assign o_cy = cy_r;
  assign o_tot = tot_r;

  `FDC_ASSERT_IMP(a_no_take_busy, st_r != fdcc_pkg::ST_ACC, !q_rd)
  `FDC_ASSERT_IMP(a_res_only_out, o_ne, st_r == fdcc_pkg::ST_OUT)
  `FDC_ASSERT_NXT(a_clear_after, fin, cc_r == '0 && pt_r == '0)
endmodule

@@ design/frame_diff_change_centroid_top.sv @@
// Top level of the frame-difference change centroid block.
// Depends on fdcc_pkg, fdcc_front, fdcc_queue, fdcc_back.
//   channel | ports                       | handshake
//   input   | in_* pixel pair fields      | in_push / in_full
//   result  | out_* centroid fields       | out_pop / out_empty
//   config  | cfg_we, cfg_index, cfg_data | write enable only
// One pixel per cycle, while in_full is low, through the two-stage ratio test into
// a 4-entry queue. A last pixel passes the two front registers and the queue to
// an idle back end, which loads the sums and runs the 37-step shift-subtract
// divider, then registers the result. It holds until popped, then clears the sums;
// meanwhile in_full rises once two queue entries wait. Synchronous active-low reset.
module frame_diff_change_centroid_top (
  input  logic clk,
  input  logic rst_n,
  input  logic in_push,
  output logic in_full,
  input  logic [7:0] in_ref_blue, in_ref_green, in_ref_red,
  input  logic [7:0] in_cur_blue, in_cur_green, in_cur_red,
  input  logic [10:0] in_pixel_x, in_pixel_y,
  input  logic in_last_pixel,
  output logic out_empty,
  input  logic out_pop,
  output logic out_centroid_valid,
  output logic [14:0] out_centroid_x, out_centroid_y,
  output logic [22:0] out_changed_total,
  input  logic cfg_we,
  input  logic [fdcc_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [fdcc_pkg::CfgDatW-1:0] cfg_data
);
  logic [fdcc_pkg::ThrW-1:0] thr_r;
  logic [fdcc_pkg::TolW-1:0] lum_r, red_r, grn_r, blu_r;
  logic go, f_vld, q_ne, q_rd, o_ne;
  fdcc_pkg::pix_t f_pix, q_pix;
  logic [fdcc_pkg::QAw:0] lvl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
      lum_r <= 24'd6554;
      red_r <= 24'd3277;
      grn_r <= 24'd3277;
      blu_r <= 24'd3277;
    end else if (cfg_we) begin
      case (cfg_index)
        fdcc_pkg::REG_THRESH: thr_r <= cfg_data[fdcc_pkg::ThrW-1:0];
        fdcc_pkg::REG_LUMIN:  lum_r <= cfg_data;
        fdcc_pkg::REG_RED:    red_r <= cfg_data;
        fdcc_pkg::REG_GREEN:  grn_r <= cfg_data;
        fdcc_pkg::REG_BLUE:   blu_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // two items may be in the front stages; keep room for them
  assign in_full = lvl > 3'(fdcc_pkg::QDepth - 3);
  assign go = in_push && !in_full;

  fdcc_front u_front (
    .clk, .rst_n, .in_go(go),
    .ref_b(in_ref_blue), .ref_g(in_ref_green), .ref_r(in_ref_red),
    .cur_b(in_cur_blue), .cur_g(in_cur_green), .cur_r(in_cur_red),
    .px(in_pixel_x), .py(in_pixel_y), .lst(in_last_pixel),
    .lum_tol(lum_r), .red_tol(red_r), .grn_tol(grn_r), .blu_tol(blu_r),
    .o_vld(f_vld), .o_pix(f_pix)
  );

  fdcc_queue u_queue (
    .clk, .rst_n, .wr(f_vld), .wdata(f_pix), .rd(q_rd),
    .nonempty(q_ne), .rdata(q_pix), .level(lvl)
  );

  fdcc_back u_back (
    .clk, .rst_n, .q_ne, .q_pix, .q_rd, .thr(thr_r),
    .o_ne, .o_pop(out_pop), .o_valid(out_centroid_valid),
    .o_cx(out_centroid_x), .o_cy(out_centroid_y), .o_tot(out_changed_total)
  );

  assign out_empty = !o_ne;
endmodule
